// File: src/dmc_pkg.sv
package dmc_pkg;

    localparam int ADDR_W   = 10;
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 11;
    localparam int BLK_W    = 5;
    localparam int OFF_W    = 4;
    localparam int STATUS_W = 3;

    localparam int MEM_DEPTH_DEF = 1024;
    localparam int MAX_LINES_DEF = 64;
    localparam int MAX_BLOCK_DEF = 16;

    localparam logic [SIZE_W-1:0] MEM_WORDS_RST   = 11'd1024;
    localparam logic [SIZE_W-1:0] CACHE_WORDS_RST = 11'd64;
    localparam logic [BLK_W-1:0]  BLOCK_WORDS_RST = 5'd4;

    localparam logic [1:0] REG_MEM_WORDS   = 2'd0;
    localparam logic [1:0] REG_CACHE_WORDS = 2'd1;
    localparam logic [1:0] REG_BLOCK_WORDS = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG  = 3'd4;

    typedef enum logic [1:0] {
        DIV_TAG,
        DIV_LINE,
        DIV_OFF
    } div_sel_t;

    typedef enum logic [1:0] {
        OUT_OK,
        OUT_BAD_ADDR,
        OUT_BAD_CFG
    } out_kind_t;

    typedef struct packed {
        logic      init_step;
        logic      cap;
        logic      div_go;
        div_sel_t  div_sel;
        logic      look;
        logic      cmp;
        logic      miss_upd;
        logic      ld_rd;
        logic      ld_wr;
        logic      rd_word;
        logic      out_ld;
        out_kind_t out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic in_valid;
        logic div_done;
        logic addr_bad;
        logic cfg_bad;
        logic line_bad;
        logic hit;
        logic ld_last;
        logic out_busy;
    } dp_status_t;

endpackage

// File: src/direct_mapped_cache_write_through_unit.sv
// Access steps: serial divisions for the tag, the line and the offset (one
// quotient bit per cycle), a tag lookup and a compare; a miss adds a tag update
// and a block fill that reads each word from main memory into the data memory.
// Bad address or sizes end the access at the check, a bad line index after the
// divisions. One access at a time; the next input transfer can be taken in the
// cycle after the result is loaded, also while that result waits. Reset: memory
// initialization sweep of MEM_DEPTH cycles before the first input transfer;
// configuration writes are taken during the sweep.
module direct_mapped_cache_write_through_unit #(
    parameter int MEM_DEPTH = dmc_pkg::MEM_DEPTH_DEF,
    parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
    parameter int MAX_BLOCK = dmc_pkg::MAX_BLOCK_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address[9:0], write_value[41:10]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // tag_out[9:0], line_out[19:10], offset_out[23:20],
                                   // read_data[55:24]
    output logic [2:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dmc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign pready = 1'b1;

    dmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    dmc_datapath #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAX_LINES (MAX_LINES),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

// File: src/dmc_ram.sv
module dmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dmc_div.sv
module dmc_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dmc_pkg::ADDR_W-1:0] dividend,
    input  logic [dmc_pkg::SIZE_W-1:0] divisor,
    output logic [dmc_pkg::ADDR_W-1:0] quotient,
    output logic [dmc_pkg::SIZE_W-1:0] remainder,
    output logic                      done
);
    import dmc_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic [ADDR_W-1:0] q_reg, q_next;
    logic [SIZE_W-1:0] r_reg, r_next;
    logic [SIZE_W-1:0] d_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [SIZE_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_reg, q_reg[ADDR_W-1]};
        if (trial >= {1'b0, d_reg}) begin
            r_next = SIZE_W'(trial - {1'b0, d_reg});
            q_next = {q_reg[ADDR_W-2:0], 1'b1};
        end else begin
            r_next = trial[SIZE_W-1:0];
            q_next = {q_reg[ADDR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(ADDR_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (cnt_reg != '0) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule

// File: src/dmc_datapath.sv
module dmc_datapath #(
    parameter int MEM_DEPTH = dmc_pkg::MEM_DEPTH_DEF,
    parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
    parameter int MAX_BLOCK = dmc_pkg::MAX_BLOCK_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dmc_pkg::ctrl_cmd_t   cmd,
    output dmc_pkg::dp_status_t  sts,
    input  logic                 s_tvalid,
    input  logic [47:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,
    output logic [2:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata
);
    import dmc_pkg::*;

    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int DAW = (MAX_LINES * MAX_BLOCK > 1) ? $clog2(MAX_LINES * MAX_BLOCK) : 1;

    // configuration
    logic [SIZE_W-1:0] mem_words_reg, cache_words_reg;
    logic [BLK_W-1:0]  block_words_reg;
    logic              cfg_wr;
    logic [MAX_LINES-1:0] valid_reg;

    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_MEM_WORDS:   prdata = {21'b0, mem_words_reg};
            REG_CACHE_WORDS: prdata = {21'b0, cache_words_reg};
            REG_BLOCK_WORDS: prdata = {27'b0, block_words_reg};
            default:         prdata = '0;
        endcase
    end

    // captured item and address split
    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] val_reg;
    logic [ADDR_W-1:0] tag_reg, line_reg;
    logic [SIZE_W-1:0] remc_reg, rem2_reg;
    logic [BLK_W-1:0]  off_reg;
    div_sel_t          sel_reg;
    logic [BLK_W-1:0]  idx_reg;
    logic              ok_reg;
    logic [MAW-1:0]    init_reg;
    logic [STATUS_W-1:0] st_reg;

    logic [ADDR_W-1:0] div_q;
    logic [SIZE_W-1:0] div_r;
    logic              div_done;
    logic [ADDR_W-1:0] div_a;
    logic [SIZE_W-1:0] div_d;

    always_comb begin
        div_a = addr_reg;
        div_d = cache_words_reg;
        unique case (cmd.div_sel)
            DIV_TAG:  begin div_a = addr_reg; div_d = cache_words_reg; end
            DIV_LINE: begin
                div_a = ADDR_W'(remc_reg);
                div_d = {6'b0, block_words_reg};
            end
            DIV_OFF:  begin div_a = addr_reg; div_d = {6'b0, block_words_reg}; end
            default:  begin div_a = addr_reg; div_d = cache_words_reg; end
        endcase
    end

    dmc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_go),
        .dividend  (div_a),
        .divisor   (div_d),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // memories
    logic [LW-1:0]     line_idx;
    logic [ADDR_W:0]   ld_addr;
    logic [MAW-1:0]    mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] tag_rdata;
    logic [DAW-1:0]    dat_waddr, dat_raddr;
    logic [DATA_W-1:0] dat_rdata;
    logic              ld_ok;

    assign line_idx = LW'(line_reg);
    // block base is address minus offset
    assign ld_addr  = {1'b0, addr_reg} - {7'b0, off_reg[OFF_W-1:0]} + {6'b0, idx_reg};
    assign ld_ok    = (ld_addr < {1'b0, mem_words_reg})
                      && (32'(ld_addr) < 32'(MEM_DEPTH));

    assign mem_we    = cmd.init_step || (cmd.miss_upd && cmd_reg == CMD_WRITE);
    assign mem_waddr = cmd.init_step ? init_reg : MAW'(addr_reg);
    assign mem_wdata = cmd.init_step ? (32'(MEM_DEPTH) - 32'(init_reg)) : val_reg;
    assign mem_raddr = MAW'(ld_addr);

    assign dat_waddr = DAW'(32'(line_idx) * MAX_BLOCK + 32'(idx_reg));
    assign dat_raddr = DAW'(32'(line_idx) * MAX_BLOCK + 32'(off_reg));

    dmc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_main (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.ld_rd),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dmc_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LINES)) u_tag (
        .aclk  (aclk),
        .we    (cmd.miss_upd),
        .waddr (line_idx),
        .wdata (tag_reg),
        .re    (cmd.look),
        .raddr (line_idx),
        .rdata (tag_rdata)
    );

    dmc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LINES * MAX_BLOCK)) u_data (
        .aclk  (aclk),
        .we    (cmd.ld_wr),
        .waddr (dat_waddr),
        .wdata (ok_reg ? mem_rdata : '0),
        .re    (cmd.look || cmd.rd_word),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    // status toward the controller
    logic            line_valid;
    logic            tag_match;
    logic [SIZE_W:0] line_end;

    assign line_valid = valid_reg[line_idx];
    assign tag_match  = line_valid && (tag_rdata == tag_reg);
    // line >= cache_words / block_words  <=>  line * block_words + block_words > cache_words
    assign line_end   = {1'b0, remc_reg} - {1'b0, rem2_reg} + {7'b0, block_words_reg};

    always_comb begin
        sts.init_last = (32'(init_reg) == MEM_DEPTH - 1);
        sts.in_valid  = s_tvalid;
        sts.div_done  = div_done;
        sts.addr_bad  = !(({1'b0, addr_reg} < mem_words_reg)
                          && (32'(addr_reg) < 32'(MEM_DEPTH)));
        sts.cfg_bad   = (cache_words_reg == '0) || (block_words_reg == '0)
                        || (32'(block_words_reg) > MAX_BLOCK);
        sts.line_bad  = (line_end > {1'b0, cache_words_reg})
                        || (32'(line_reg) >= MAX_LINES);
        sts.hit       = tag_match
                        && (cmd_reg == CMD_READ || dat_rdata == val_reg);
        sts.ld_last   = (idx_reg == block_words_reg - 1'b1);
        sts.out_busy  = m_tvalid && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_words_reg   <= MEM_WORDS_RST;
            cache_words_reg <= CACHE_WORDS_RST;
            block_words_reg <= BLOCK_WORDS_RST;
            valid_reg       <= '0;
            init_reg        <= '0;
            m_tvalid        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_MEM_WORDS:   mem_words_reg   <= pwdata[SIZE_W-1:0];
                    REG_CACHE_WORDS: cache_words_reg <= pwdata[SIZE_W-1:0];
                    REG_BLOCK_WORDS: block_words_reg <= pwdata[BLK_W-1:0];
                    default: ;
                endcase
                if ((paddr[3:2] == REG_MEM_WORDS) || (paddr[3:2] == REG_CACHE_WORDS)
                    || (paddr[3:2] == REG_BLOCK_WORDS)) begin
                    valid_reg <= '0;
                end
            end else if (cmd.miss_upd) begin
                valid_reg[line_idx] <= 1'b1;
            end
            if (cmd.init_step) begin
                init_reg <= init_reg + 1'b1;
            end
            if (cmd.out_ld) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[ADDR_W-1:0];
            val_reg  <= s_tdata[ADDR_W +: DATA_W];
        end
        if (cmd.div_go) begin
            sel_reg <= cmd.div_sel;
        end
        if (div_done) begin
            unique case (sel_reg)
                DIV_TAG:  begin tag_reg <= div_q; remc_reg <= div_r; end
                DIV_LINE: begin line_reg <= div_q; rem2_reg <= div_r; end
                DIV_OFF:  off_reg <= div_r[BLK_W-1:0];
                default: ;
            endcase
        end
        if (cmd.cmp) begin
            st_reg <= line_valid ? ST_MISS : ST_ALLOC;
            if (sts.hit) begin
                st_reg <= ST_HIT;
            end
        end
        if (cmd.miss_upd) begin
            idx_reg <= '0;
        end else if (cmd.ld_wr) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.ld_rd) begin
            ok_reg <= ld_ok;
        end
        if (cmd.out_ld) begin
            unique case (cmd.out_kind)
                OUT_OK: begin
                    m_tuser <= st_reg;
                    m_tdata <= {dat_rdata, off_reg[OFF_W-1:0], line_reg, tag_reg};
                end
                OUT_BAD_ADDR: begin
                    m_tuser <= ST_BAD_ADDR;
                    m_tdata <= '0;
                end
                default: begin
                    m_tuser <= ST_BAD_CFG;
                    m_tdata <= '0;
                end
            endcase
        end
    end

endmodule

// File: src/dmc_ctrl.sv
module dmc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  dmc_pkg::dp_status_t sts,
    output dmc_pkg::ctrl_cmd_t  cmd,
    output logic                s_tready
);
    import dmc_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CHK, S_DIV1, S_W1, S_DIV2, S_W2, S_DIV3, S_W3,
        S_LINE, S_LOOK, S_CMP, S_UPD, S_LDR, S_LDW, S_RD, S_OUT
    } state_t;

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.out_kind = kind_reg;
        cmd.div_sel  = DIV_TAG;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                cmd.cap = sts.in_valid;
                if (sts.in_valid) state_next = S_CHK;
            end
            S_CHK: begin
                kind_next = OUT_OK;
                priority if (sts.addr_bad) begin
                    kind_next  = OUT_BAD_ADDR;
                    state_next = S_OUT;
                end else if (sts.cfg_bad) begin
                    kind_next  = OUT_BAD_CFG;
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                cmd.div_go = 1'b1;
                state_next = S_W1;
            end
            S_W1: if (sts.div_done) state_next = S_DIV2;
            S_DIV2: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_LINE;
                state_next  = S_W2;
            end
            S_W2: if (sts.div_done) state_next = S_DIV3;
            S_DIV3: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_OFF;
                state_next  = S_W3;
            end
            S_W3: if (sts.div_done) state_next = S_LINE;
            S_LINE: begin
                if (sts.line_bad) begin
                    kind_next  = OUT_BAD_CFG;
                    state_next = S_OUT;
                end else begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = sts.hit ? S_RD : S_UPD;
            end
            S_UPD: begin
                cmd.miss_upd = 1'b1;
                state_next   = S_LDR;
            end
            S_LDR: begin
                cmd.ld_rd  = 1'b1;
                state_next = S_LDW;
            end
            S_LDW: begin
                cmd.ld_wr  = 1'b1;
                state_next = sts.ld_last ? S_RD : S_LDR;
            end
            S_RD: begin
                cmd.rd_word = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            kind_reg  <= OUT_OK;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// File: verif/tb_direct_mapped_cache_write_through_unit.sv
`timescale 1ns / 100ps

module tb_direct_mapped_cache_write_through_unit;
    import dmc_pkg::*;

    localparam int MEM_D     = 1024;
    localparam int LINES     = 64;
    localparam int BLK_MAX   = 16;
    localparam int IDLE_WAIT = 120;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [9:0]          tag;
        logic [9:0]          line;
        logic [OFF_W-1:0]    off;
        logic [DATA_W-1:0]   data;
    } access_result_t;

    class cache_scoreboard;
        logic [DATA_W-1:0] memory [MEM_D];
        logic              vld [LINES];
        logic [9:0]        tags [LINES];
        logic [DATA_W-1:0] words [LINES*BLK_MAX];
        int unsigned       mem_words, cache_words, block_words;
        access_result_t    pending_q [$];
        int                errors;

        function new();
            for (int i = 0; i < MEM_D; i++) memory[i] = MEM_D - i;
            for (int i = 0; i < LINES*BLK_MAX; i++) words[i] = '0;
            for (int i = 0; i < LINES; i++) begin
                vld[i]  = 1'b0;
                tags[i] = '0;
            end
            mem_words   = MEM_WORDS_RST;
            cache_words = CACHE_WORDS_RST;
            block_words = BLOCK_WORDS_RST;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MEM_WORDS:   mem_words   = value[SIZE_W-1:0];
                REG_CACHE_WORDS: cache_words = value[SIZE_W-1:0];
                REG_BLOCK_WORDS: block_words = value[BLK_W-1:0];
                default: return;
            endcase
            for (int i = 0; i < LINES; i++) vld[i] = 1'b0;
        endfunction

        function logic [DATA_W-1:0] mem_word(int unsigned a);
            return memory[a % MEM_D];
        endfunction

        function bit in_mem(int unsigned a);
            return a < mem_words && a < MEM_D;
        endfunction

        function void note(logic cmd, logic [9:0] addr, logic [DATA_W-1:0] val);
            access_result_t r;
            int unsigned a, t, l, o, base, ba;
            bit hit;
            r = '0;
            a = addr;
            if (!in_mem(a)) begin
                r.status = ST_BAD_ADDR;
            end else if (cache_words == 0 || block_words == 0 || block_words > BLK_MAX) begin
                r.status = ST_BAD_CFG;
            end else begin
                t = a / cache_words;
                l = (a % cache_words) / block_words;
                o = a % block_words;
                if (l >= cache_words / block_words || l >= LINES) begin
                    r.status = ST_BAD_CFG;
                end else begin
                    base = (a / block_words) * block_words;
                    hit = vld[l] && tags[l] == t &&
                          (cmd == CMD_READ || words[l*BLK_MAX+o] == val);
                    if (hit) begin
                        r.status = ST_HIT;
                    end else begin
                        r.status = vld[l] ? ST_MISS : ST_ALLOC;
                        vld[l]  = 1'b1;
                        tags[l] = 10'(t);
                        if (cmd == CMD_WRITE) memory[a] = val;
                        for (int i = 0; i < block_words; i++) begin
                            ba = base + i;
                            words[l*BLK_MAX+i] = in_mem(ba) ? memory[ba] : '0;
                        end
                    end
                    r.tag  = 10'(t);
                    r.line = 10'(l);
                    r.off  = OFF_W'(o);
                    r.data = words[l*BLK_MAX+o];
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check(logic [2:0] st, logic [55:0] td);
            access_result_t e;
            if (pending_q.size() == 0) begin
                $error("result with no pending access: status %0d data %h", st, td);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st != e.status) begin
                $error("status: expected %0d actual %0d", e.status, st);
                errors++;
            end
            if (td[9:0] != e.tag) begin
                $error("tag_out: expected %0d actual %0d", e.tag, td[9:0]);
                errors++;
            end
            if (td[19:10] != e.line) begin
                $error("line_out: expected %0d actual %0d", e.line, td[19:10]);
                errors++;
            end
            if (td[23:20] != e.off) begin
                $error("offset_out: expected %0d actual %0d", e.off, td[23:20]);
                errors++;
            end
            if (td[55:24] != e.data) begin
                $error("read_data: expected %h actual %h", e.data, td[55:24]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid, m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    cache_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_left  = 0;
    logic [9:0] recent [8];

    direct_mapped_cache_write_through_unit dut (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // result side: scoreboard check, random backpressure and watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tuser, m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < 2) begin
            stall_left <= $urandom_range(20, 60);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_access(logic cmd, logic [9:0] addr, logic [31:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, val, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note(cmd, addr, val);
        recent[$urandom_range(0, 7)] = addr;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // the last transfer may leave tvalid high; drop it so it is not taken again
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic configure(int unsigned mw, int unsigned cw, int unsigned bw);
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        reg_write(REG_MEM_WORDS, mw);
        reg_write(REG_CACHE_WORDS, cw);
        reg_write(REG_BLOCK_WORDS, bw);
    endtask

    task automatic random_accesses(int n);
        int r;
        logic [9:0] a;
        logic [31:0] v;
        logic c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)      a = 10'($urandom_range(0, 63));
            else if (r < 75) a = recent[$urandom_range(0, 7)];
            else             a = 10'($urandom_range(0, 1023));
            c = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 50)      v = sb.mem_word(a);  // likely a write hit
            else if (r < 60) v = (r < 55) ? 32'h8000_0000 : 32'h7fff_ffff;
            else             v = $urandom;
            send_access(c, a, v);
            if (i == n / 2 && n > 40) drain();   // sender waits for all results
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) recent[i] = 10'(i);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset configuration
        send_access(CMD_READ,  10'd0,    32'd0);
        send_access(CMD_READ,  10'd1,    32'd0);
        send_access(CMD_WRITE, 10'd2,    32'd1022);       // matching write
        send_access(CMD_WRITE, 10'd2,    32'h8000_0000);
        send_access(CMD_WRITE, 10'd3,    32'h7fff_ffff);
        send_access(CMD_WRITE, 10'd3,    32'hffff_ffff);
        send_access(CMD_READ,  10'd3,    32'd0);
        send_access(CMD_READ,  10'd64,   32'd0);          // conflict on line 0
        send_access(CMD_READ,  10'd1023, 32'd0);
        send_access(CMD_WRITE, 10'd1023, 32'd0);
        send_access(CMD_READ,  10'd0,    32'd0);
        drain();

        configure(300, 48, 16);                           // block runs past memory
        send_access(CMD_READ,  10'd290, 32'd0);
        send_access(CMD_READ,  10'd300, 32'd0);           // bad address
        send_access(CMD_WRITE, 10'd1023, 32'd5);
        send_access(CMD_READ,  10'd50,  32'd0);           // maps to line 0, conflicting with address 290
        drain();
        configure(1024, 0, 4);
        send_access(CMD_READ, 10'd5, 32'd0);
        drain();
        configure(1024, 64, 0);
        send_access(CMD_WRITE, 10'd5, 32'd9);
        drain();
        configure(1024, 64, 17);
        send_access(CMD_READ, 10'd5, 32'd0);
        drain();
        configure(0, 64, 4);
        send_access(CMD_READ, 10'd0, 32'd0);
        drain();

        configure(1024, 64, 4);
        random_accesses(80);
        drain();
        configure(1024, 1024, 16);
        random_accesses(70);
        drain();
        configure(1, 1, 1);
        random_accesses(40);
        drain();
        configure(1000, 1024, 1);
        random_accesses(60);
        drain();
        configure(300, 48, 16);
        random_accesses(60);
        drain();
        configure(512, 20, 3);
        random_accesses(60);
        drain();
        configure(2047, 2047, 31);
        random_accesses(20);
        drain();
        configure(1024, 16, 2);
        random_accesses(70);
        drain();
        configure(1024, 1024, 16);
        random_accesses(40);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
